### hdl/csrspmv_pkg.sv
package csrspmv_pkg;

	// sizes of the vector store and of the row space
	localparam int unsigned VECTOR_DEPTH = 4096;
	localparam int unsigned MAX_ROWS = 1048576;
	localparam int ADDR_W = $clog2(VECTOR_DEPTH);

	// field widths
	localparam int OP_W = 2;
	localparam int COL_W = 12;
	localparam int VAL_W = 32;
	localparam int ROW_W = 20;
	localparam int STOP_W = 21;
	localparam int ACC_W = 64;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// request opcodes
	localparam logic [OP_W-1:0] OP_WRITE_X = 2'd0;
	localparam logic [OP_W-1:0] OP_NONZERO = 2'd1;
	localparam logic [OP_W-1:0] OP_EMPTY_ROW = 2'd2;

	// configuration registers
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 21;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROW = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_ROW = 1'b1;

	// one unit of work for the back part
	typedef struct packed {
		logic nonzero;
		logic row_last;
		logic signed [VAL_W-1:0] a_val;
		logic signed [VAL_W-1:0] x_val;
	} work_t;

	// Q32.32 to Q16.16: floor, then saturate to 32 bits
	function automatic logic [VAL_W-1:0] to_q16(input logic [ACC_W-1:0] acc);
		logic pos_ovf;
		logic neg_ovf;
		pos_ovf = !acc[63] && (acc[62:47] != '0);
		neg_ovf = acc[63] && (acc[62:47] != '1);
		if (pos_ovf) begin
			return 32'h7FFF_FFFF;
		end else if (neg_ovf) begin
			return 32'h8000_0000;
		end else begin
			return acc[47:16];
		end
	endfunction

endpackage

### hdl/csrspmv_if.sv
interface csrspmv_req_if;
	import csrspmv_pkg::*;
	logic valid;
	logic ready;
	logic [OP_W-1:0] opcode;
	logic [COL_W-1:0] column;
	logic signed [VAL_W-1:0] item_value;
	logic row_last;
	modport source(output valid, opcode, column, item_value, row_last, input ready);
	modport sink(input valid, opcode, column, item_value, row_last, output ready);
endinterface

interface csrspmv_rsp_if;
	import csrspmv_pkg::*;
	logic valid;
	logic ready;
	logic [ROW_W-1:0] row_index;
	logic signed [VAL_W-1:0] row_sum;
	logic band_done;
	modport source(output valid, row_index, row_sum, band_done, input ready);
	modport sink(input valid, row_index, row_sum, band_done, output ready);
endinterface

### hdl/csrspmv_front.sv
module csrspmv_front (
	input logic clk,
	input logic arst_n,
	csrspmv_req_if.sink req,
	input logic [csrspmv_pkg::QCNT_W-1:0] q_count,
	output logic push,
	output csrspmv_pkg::work_t push_entry
);
	import csrspmv_pkg::*;

	logic accept;
	logic col_ok;
	logic [ADDR_W-1:0] addr;
	logic valid_s1;
	logic nonzero_s1;
	logic last_s1;
	logic xzero_s1;
	logic signed [VAL_W-1:0] value_s1;
	logic signed [VAL_W-1:0] rd_q;
	logic signed [VAL_W-1:0] mem_q [VECTOR_DEPTH];

	// reserve a queue slot for the request held in stage 1
	assign req.ready = ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(valid_s1))
		< (QCNT_W+1)'(QUEUE_DEPTH);
	assign accept = req.valid && req.ready;
	assign col_ok = 32'(req.column) < 32'(VECTOR_DEPTH);
	assign addr = ADDR_W'(req.column);

	// vector store: write x entries, read x for nonzeros
	always_ff @(posedge clk) begin
		if (accept && req.opcode == OP_WRITE_X && col_ok) begin
			mem_q[addr] <= req.item_value;
		end
		if (accept && req.opcode == OP_NONZERO) begin
			rd_q <= mem_q[addr];
		end
	end

	// classify: only nonzeros and empty rows go on to the back part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && (req.opcode == OP_NONZERO || req.opcode == OP_EMPTY_ROW);
		end
	end

	// hold the request fields next to the read
	always_ff @(posedge clk) begin
		if (accept) begin
			nonzero_s1 <= req.opcode == OP_NONZERO;
			last_s1 <= req.row_last;
			value_s1 <= req.item_value;
			xzero_s1 <= !col_ok;
		end
	end

	assign push = valid_s1;
	assign push_entry = '{
		nonzero: nonzero_s1,
		row_last: last_s1,
		a_val: value_s1,
		x_val: xzero_s1 ? '0 : rd_q
	};

endmodule

### hdl/csrspmv_queue.sv
module csrspmv_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input csrspmv_pkg::work_t push_entry,
	input logic pop,
	output csrspmv_pkg::work_t pop_entry,
	output logic [csrspmv_pkg::QCNT_W-1:0] count,
	output logic empty
);
	import csrspmv_pkg::*;

	work_t entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_entry;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	assign pop_entry = entries_q[rd_q];
	assign count = cnt_q;
	assign empty = cnt_q == '0;

endmodule

### hdl/csrspmv_back.sv
module csrspmv_back (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [csrspmv_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [csrspmv_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic empty,
	input csrspmv_pkg::work_t pop_entry,
	output logic pop,
	csrspmv_rsp_if.source rsp
);
	import csrspmv_pkg::*;

	logic adv;
	logic [ROW_W-1:0] first_q;
	logic [STOP_W-1:0] stop_q;
	logic [ROW_W-1:0] cur_q;
	logic [ACC_W-1:0] acc_q;

	logic valid_s1;
	logic nonzero_s1;
	logic last_s1;
	logic signed [ACC_W-1:0] prod_s1;
	logic signed [ACC_W-1:0] prod;

	logic valid_s2;
	logic [ACC_W-1:0] sum_s2;
	logic [ROW_W-1:0] row_s2;
	logic done_s2;

	logic out_valid_q;
	logic [ROW_W-1:0] out_row_q;
	logic [VAL_W-1:0] out_sum_q;
	logic out_done_q;

	logic emit;
	logic [ACC_W:0] wide;
	logic [ACC_W-1:0] sum_sat;
	logic [STOP_W-1:0] row_inc;
	logic done;
	logic [ROW_W-1:0] row_next;

	// the whole back pipe moves when the output register can take a result
	assign adv = !out_valid_q || rsp.ready;
	assign pop = adv && !empty;
	assign prod = $signed(pop_entry.a_val) * $signed(pop_entry.x_val);

	// stage 1: multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			nonzero_s1 <= pop_entry.nonzero;
			last_s1 <= pop_entry.row_last;
			prod_s1 <= pop_entry.nonzero ? prod : '0;
		end
	end

	// saturating accumulate and row bookkeeping
	always_comb begin
		wide = {acc_q[ACC_W-1], acc_q} + {prod_s1[ACC_W-1], prod_s1};
		if (wide[ACC_W] != wide[ACC_W-1]) begin
			sum_sat = wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			sum_sat = wide[ACC_W-1:0];
		end
		emit = valid_s1 && (!nonzero_s1 || last_s1);
		row_inc = {1'b0, cur_q} + STOP_W'(1);
		done = row_inc >= stop_q;
		if (done) begin
			row_next = first_q;
		end else if (32'(row_inc) >= 32'(MAX_ROWS)) begin
			row_next = '0;
		end else begin
			row_next = row_inc[ROW_W-1:0];
		end
	end

	// configuration and accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			stop_q <= '0;
			cur_q <= '0;
			acc_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST_ROW: begin
					first_q <= cfg_data[ROW_W-1:0];
					cur_q <= cfg_data[ROW_W-1:0];
					acc_q <= '0;
				end
				CFG_STOP_ROW: begin
					stop_q <= cfg_data[STOP_W-1:0];
				end
				default: begin
				end
			endcase
		end else if (adv && valid_s1) begin
			acc_q <= emit ? '0 : sum_sat;
			if (emit) begin
				cur_q <= row_next;
			end
		end
	end

	// stage 2: finished row sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			sum_s2 <= sum_sat;
			row_s2 <= cur_q;
			done_s2 <= done;
		end
	end

	// output register: round down and saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			out_row_q <= row_s2;
			out_sum_q <= to_q16(sum_s2);
			out_done_q <= done_s2;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.row_index = out_row_q;
	assign rsp.row_sum = out_sum_q;
	assign rsp.band_done = out_done_q;

endmodule

### hdl/csr_sparse_matrix_vector_multiply_top.sv
// Sparse matrix times dense vector for one band of rows in compressed-row form.
// Requests arrive on req (valid/ready): opcode 0 writes item_value into the
// x vector at column, opcode 1 multiplies a nonzero by x[column] and adds it
// to the row sum, opcode 2 closes an empty row; opcode 3 is dropped. A nonzero
// with row_last set, or an empty row, sends one result on rsp: the row index,
// the Q16.16 sum (rounded down, saturated) and band_done for the band's last row.
// Configuration goes through cfg_we/cfg_index/cfg_data while the block is idle;
// writing first_row also restarts the band.
// Throughput: one request per cycle while rsp is not stalled, set by the single
// multiply-accumulate in the back part and the single vector store port in the
// front part. A closing request passes front stage 1, the queue, back stages 1
// and 2 and the output register. A 4-entry queue parts the front from the back.
// Reset clears the queue, the pipeline, the accumulator and the row counter;
// the x vector is not cleared and must be written before it is used.
// When rsp stalls, the result holds in the output register, the back part
// stops, and req keeps taking requests until the queue is full.
module csr_sparse_matrix_vector_multiply_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [csrspmv_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [csrspmv_pkg::CFG_DATA_W-1:0] cfg_data,
	csrspmv_req_if.sink req,
	csrspmv_rsp_if.source rsp
);
	import csrspmv_pkg::*;

	logic push;
	work_t push_entry;
	logic pop;
	work_t pop_entry;
	logic [QCNT_W-1:0] q_count;
	logic q_empty;

	csrspmv_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.q_count(q_count),
		.push(push),
		.push_entry(push_entry)
	);

	csrspmv_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.pop_entry(pop_entry),
		.count(q_count),
		.empty(q_empty)
	);

	csrspmv_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.empty(q_empty),
		.pop_entry(pop_entry),
		.pop(pop),
		.rsp(rsp)
	);

endmodule

### hdl/csrspmv_checker.sv
module csrspmv_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [csrspmv_pkg::ROW_W-1:0] rsp_row_index,
	input logic [csrspmv_pkg::VAL_W-1:0] rsp_row_sum
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_index) && $stable(rsp_row_sum))
		else $error("stalled result changed");

	// ready drops only after a request took a queue slot
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(req_ready) |-> $past(req_valid && req_ready))
		else $error("ready dropped without an accepted request");

	// in reset no result is offered and the queue is open
	assert property (@(posedge clk) !arst_n |-> !rsp_valid && req_ready)
		else $error("reset state wrong");

endmodule

bind csr_sparse_matrix_vector_multiply_top csrspmv_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_row_index(rsp.row_index),
	.rsp_row_sum(rsp.row_sum)
);

### tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import csrspmv_pkg::*;

	// opcode that the block drops
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	// cycles a request that gives no result may still spend in the pipeline
	localparam int SETTLE_CYCLES = 10;
	// cycles with no request or result moving before the run is declared hung
	localparam int HANG_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1850;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic signed [VAL_W-1:0] sum;
		logic done;
	} row_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	csrspmv_req_if req_ch();
	csrspmv_rsp_if rsp_ch();

	csr_sparse_matrix_vector_multiply_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// band state as the block should hold it
	logic signed [VAL_W-1:0] x_vec [VECTOR_DEPTH];
	bit x_known [VECTOR_DEPTH];
	logic [COL_W-1:0] x_cols[$];
	logic signed [ACC_W-1:0] row_acc;
	logic [ROW_W-1:0] row_now;
	logic [ROW_W-1:0] band_first;
	logic [STOP_W-1:0] band_stop;

	row_result_t pending_rows[$];
	int error_count;
	int sent_count;
	int quiet_cycles;
	bit req_idle_on;
	bit rsp_idle_on;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// add two Q32.32 values, clamping at the 64-bit limits
	function automatic logic signed [ACC_W-1:0] acc_add_sat(input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b);
		logic [ACC_W:0] wide;
		wide = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (wide[ACC_W] != wide[ACC_W-1]) begin
			return wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end
		return wide[ACC_W-1:0];
	endfunction

	// floor a Q32.32 sum to Q16.16 and clamp to 32 bits
	function automatic logic signed [VAL_W-1:0] acc_to_q16(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] floored;
		floored = acc >>> 16;
		if (floored > 64'sh0000_0000_7FFF_FFFF) begin
			return 32'h7FFF_FFFF;
		end
		if (floored < 64'shFFFF_FFFF_8000_0000) begin
			return 32'h8000_0000;
		end
		return floored[VAL_W-1:0];
	endfunction

	// close the current row: queue its result, clear the sum, advance the row
	function automatic void close_row();
		row_result_t res;
		logic [STOP_W:0] next_row;
		next_row = {2'b00, row_now} + 1'b1;
		res.row = row_now;
		res.sum = acc_to_q16(row_acc);
		res.done = (next_row >= {1'b0, band_stop});
		pending_rows.push_back(res);
		row_acc = '0;
		row_now = res.done ? band_first : next_row[ROW_W-1:0];
	endfunction

	// apply one accepted request to the band state
	function automatic void predict_request(input logic [OP_W-1:0] op,
		input logic [COL_W-1:0] col, input logic signed [VAL_W-1:0] val, input logic last);
		case (op)
			OP_WRITE_X: begin
				x_vec[col] = val;
				if (!x_known[col]) begin
					x_known[col] = 1'b1;
					x_cols.push_back(col);
				end
			end
			OP_NONZERO: begin
				row_acc = acc_add_sat(row_acc, longint'(val) * longint'(x_vec[col]));
				if (last) begin
					close_row();
				end
			end
			OP_EMPTY_ROW: begin
				close_row();
			end
			default: ;
		endcase
	endfunction

	function automatic logic [COL_W-1:0] pick_x_col();
		return x_cols[$urandom_range(0, x_cols.size() - 1)];
	endfunction

	// Q16.16 value: full range, small magnitudes or the extremes
	function automatic logic signed [VAL_W-1:0] rand_q16();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 3))
			0: begin
				return {{14{r[17]}}, r[17:0]};
			end
			1: begin
				case (r[1:0])
					2'd0: return 32'h7FFF_FFFF;
					2'd1: return 32'h8000_0000;
					2'd2: return 32'hFFFF_FFFF;
					default: return 32'h0001_0000;
				endcase
			end
			default: begin
				return r;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// send one request after a random gap, hold it until taken, then predict
	task automatic send_request(input logic [OP_W-1:0] op, input logic [COL_W-1:0] col,
		input logic signed [VAL_W-1:0] val, input logic last);
		int gap;
		gap = req_idle_on ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.column <= col;
		req_ch.item_value <= val;
		req_ch.row_last <= last;
		do @(posedge clk); while (!req_ch.ready);
		predict_request(op, col, val, last);
		if (op != OP_UNUSED) begin
			sent_count++;
		end
	endtask

	// one well-formed row: len nonzeros ending in row_last, or an empty row
	task automatic send_row(input int len);
		if (len == 0) begin
			send_request(OP_EMPTY_ROW, COL_W'($urandom), rand_q16(), 1'($urandom));
		end else begin
			for (int k = 0; k < len; k++) begin
				send_request(OP_NONZERO, pick_x_col(), rand_q16(), k == len - 1);
			end
		end
	endtask

	// hold requests until every row result is back and the pipeline is empty
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both band registers while the block is idle
	task automatic set_band(input logic [CFG_DATA_W-1:0] first_data,
		input logic [CFG_DATA_W-1:0] stop_data);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= CFG_FIRST_ROW;
		cfg_data <= first_data;
		@(posedge clk);
		cfg_index <= CFG_STOP_ROW;
		cfg_data <= stop_data;
		@(posedge clk);
		cfg_we <= 1'b0;
		band_first = first_data[ROW_W-1:0];
		row_now = band_first;
		row_acc = '0;
		band_stop = stop_data;
	endtask

	// reset band: empty band, every row is the last one
	task automatic test_reset_band();
		send_request(OP_WRITE_X, 12'd0, 32'h7FFF_FFFF, 1'b1);
		send_request(OP_WRITE_X, 12'hFFF, 32'h8000_0000, 1'b0);
		send_request(OP_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 1'b1);
		send_request(OP_EMPTY_ROW, 12'd0, 32'd0, 1'b0);
		send_request(OP_NONZERO, 12'd0, 32'h0001_0000, 1'b1);
	endtask

	// products, rounding toward minus infinity and both saturations
	task automatic test_products_and_rounding();
		set_band(21'd5, 21'd12);
		send_request(OP_WRITE_X, 12'd1, 32'h0001_0000, 1'b0);
		send_request(OP_WRITE_X, 12'd2, 32'h0000_0001, 1'b0);
		send_request(OP_WRITE_X, 12'd3, 32'hFFFF_0000, 1'b0);
		send_request(OP_WRITE_X, 12'h555, 32'hAAAA_AAAA, 1'b0);
		send_request(OP_NONZERO, 12'd1, 32'h0001_8000, 1'b1);
		// tiny positive floors to zero, tiny negative floors to minus one LSB
		send_request(OP_NONZERO, 12'd2, 32'h0000_0001, 1'b1);
		send_request(OP_NONZERO, 12'd2, 32'hFFFF_FFFF, 1'b1);
		// sum runs past the top of the accumulator
		send_request(OP_NONZERO, 12'hFFF, 32'h8000_0000, 1'b0);
		send_request(OP_NONZERO, 12'hFFF, 32'h8000_0000, 1'b0);
		send_request(OP_NONZERO, 12'd3, 32'd0, 1'b1);
		// and past the bottom
		send_request(OP_NONZERO, 12'hFFF, 32'h7FFF_FFFF, 1'b0);
		send_request(OP_NONZERO, 12'hFFF, 32'h7FFF_FFFF, 1'b0);
		send_request(OP_NONZERO, 12'hFFF, 32'h7FFF_FFFF, 1'b1);
		// empty row flushes a sum left open
		send_request(OP_NONZERO, 12'd3, 32'h0002_0000, 1'b0);
		send_request(OP_EMPTY_ROW, 12'hAAA, 32'h5555_5555, 1'b1);
		send_request(OP_NONZERO, 12'h555, 32'h5555_5555, 1'b1);
		// band wraps back to its first row
		send_request(OP_EMPTY_ROW, 12'd0, 32'd0, 1'b0);
	endtask

	// band register extremes, row index wrap and inverted bands
	task automatic test_band_extremes();
		set_band(21'h1F_FFFE, 21'h1F_FFFF);
		repeat (3) send_row(0);
		set_band(21'h0F_FFFF, 21'h10_0000);
		send_row(0);
		set_band(21'd0, 21'h10_0000);
		send_row(2);
		set_band(21'd100, 21'd50);
		send_row(1);
		set_band(21'h0F_FFFF, 21'd0);
		send_row(0);
	endtask

	// mostly well-formed rows with random content, mixed with noise
	task automatic test_random_stream();
		int stop_at;
		int next_band_at;
		int phase_left;
		int pick;
		bit paused;
		logic [CFG_DATA_W-1:0] first_data;
		logic [CFG_DATA_W-1:0] stop_data;
		stop_at = sent_count + RANDOM_ITEMS;
		next_band_at = sent_count + 250;
		phase_left = 0;
		paused = 1'b0;
		while (sent_count < stop_at) begin
			// switch idling on either side every few dozen steps
			if (phase_left <= 0) begin
				req_idle_on = ($urandom_range(0, 3) != 0);
				rsp_idle_on = ($urandom_range(0, 3) != 0);
				phase_left = $urandom_range(20, 80);
			end
			phase_left--;
			if (sent_count >= next_band_at) begin
				case ($urandom_range(0, 3))
					0: begin
						first_data = CFG_DATA_W'($urandom_range(0, 20'hFFFFF));
						stop_data = first_data + CFG_DATA_W'($urandom_range(1, 10));
					end
					1: begin
						first_data = CFG_DATA_W'($urandom_range(0, 8));
						stop_data = first_data + CFG_DATA_W'($urandom_range(0, 6));
					end
					2: begin
						first_data = CFG_DATA_W'($urandom);
						stop_data = CFG_DATA_W'($urandom);
					end
					default: begin
						first_data = CFG_DATA_W'(20'hFFFFF - $urandom_range(0, 3));
						stop_data = $urandom_range(0, 1) ? 21'h10_0000 : 21'h1F_FFFF;
					end
				endcase
				set_band(first_data, stop_data);
				next_band_at = sent_count + $urandom_range(150, 350);
			end else if (!paused && sent_count >= stop_at - RANDOM_ITEMS / 2) begin
				drain_results();
				paused = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				send_row($urandom_range(0, 6));
			end else if (pick < 82) begin
				send_request(OP_WRITE_X, COL_W'($urandom), rand_q16(), 1'($urandom));
			end else if (pick < 88) begin
				send_request(OP_UNUSED, COL_W'($urandom), VAL_W'($urandom), 1'($urandom));
			end else if (pick < 96) begin
				send_request(OP_NONZERO, pick_x_col(), rand_q16(), 1'b0);
				send_row(0);
			end else begin
				send_request(OP_NONZERO, pick_x_col(), rand_q16(), 1'b0);
			end
		end
	endtask

	// take results after random stalls and compare with the oldest expected row
	initial begin : result_checker
		row_result_t want;
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rsp_idle_on ? $urandom_range(0, 10) : 0;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			if (pending_rows.size() == 0) begin
				report_mismatch($sformatf("unexpected result row %0h sum %h done %0b",
					rsp_ch.row_index, rsp_ch.row_sum, rsp_ch.band_done));
			end else begin
				want = pending_rows.pop_front();
				if (rsp_ch.row_index !== want.row) begin
					report_mismatch($sformatf("row_index %0h, expected %0h",
						rsp_ch.row_index, want.row));
				end
				if (rsp_ch.row_sum !== want.sum) begin
					report_mismatch($sformatf("row %0h row_sum %h, expected %h",
						want.row, rsp_ch.row_sum, want.sum));
				end
				if (rsp_ch.band_done !== want.done) begin
					report_mismatch($sformatf("row %0h band_done %0b, expected %0b",
						want.row, rsp_ch.band_done, want.done));
				end
			end
		end
	end

	// count cycles in which nothing moves on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= HANG_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin : test_sequence
		sent_count = 0;
		req_idle_on = 1'b1;
		rsp_idle_on = 1'b1;
		row_acc = '0;
		row_now = '0;
		band_first = '0;
		band_stop = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FIRST_ROW;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_WRITE_X;
		req_ch.column = '0;
		req_ch.item_value = '0;
		req_ch.row_last = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_band();
		test_products_and_rounding();
		test_band_extremes();
		test_random_stream();
		drain_results();

		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
